@@ rtl/cursor_sprite_decode_scale_top_defines.svh @@
// ----------------------------------------------------------------------------
// cursor_sprite_decode_scale_top_defines
// Assertion macros used by the sprite decode/scale sequencer (csds_ctrl).
// ----------------------------------------------------------------------------
`ifndef CURSOR_SPRITE_DECODE_SCALE_TOP_DEFINES_SVH
`define CURSOR_SPRITE_DECODE_SCALE_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CSDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csds_pkg.sv @@
// ----------------------------------------------------------------------------
// csds_pkg
// Shared constants, types and helpers for the cursor sprite decode/scale block.
// ----------------------------------------------------------------------------
package csds_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_SCALE   = 4;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int QX_W        = $clog2(MAX_WIDTH);
  localparam int QY_W        = $clog2(MAX_HEIGHT);

  // Action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CODE  = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  localparam logic [6:0] WIDTH_RST  = 7'(MAX_WIDTH);
  localparam logic [6:0] HEIGHT_RST = 7'(MAX_HEIGHT);
  localparam logic [2:0] SCALE_RST  = 3'd1;

  typedef struct packed {
    logic start;
    logic code_pixel;
    logic set_expect;
    logic run_load;
    logic run_step;
    logic rd_capture;
    logic rd_addr;
    logic load_out;
  } csds_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic rem_one;
    logic expect_run;
    logic code_zero;
    logic run_last;
  } csds_sts_t;

  function automatic logic [6:0] clamp_dim(logic [6:0] v, logic [6:0] hi);
    logic [6:0] r;
    if (v == 7'd0) r = 7'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [2:0] clamp_scale(logic [2:0] v);
    logic [2:0] r;
    if (v == 3'd0) r = 3'd1;
    else if (v > 3'(MAX_SCALE)) r = 3'(MAX_SCALE);
    else r = v;
    return r;
  endfunction

  // Divide by scale 1..4; divide by 3 is a reciprocal multiply, exact below 512.
  function automatic logic [7:0] div_scale(logic [7:0] v, logic [2:0] s);
    logic [15:0] p;
    logic [7:0]  r;
    p = {8'd0, v} * 16'd171;
    unique case (s)
      3'd2:    r = v >> 1;
      3'd3:    r = {1'b0, p[15:9]};
      3'd4:    r = v >> 2;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/csds_datapath.sv @@
// ----------------------------------------------------------------------------
// csds_datapath
// Config registers, sprite RAM, load pointers, read address path, result reg.
// ----------------------------------------------------------------------------
module csds_datapath
  import csds_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  csds_cmd_t   cmd_i,
  output csds_sts_t   sts_o,
  input  logic [7:0]  code_byte_i,
  input  logic [7:0]  read_x_i,
  input  logic [7:0]  read_y_i,
  output logic [7:0]  pixel_value_o,
  output logic        image_done_o,
  output logic        overrun_o,
  output logic        out_of_range_o
);

  logic [6:0] width_q, height_q;
  logic [2:0] scale_q;
  logic [6:0] eff_w, eff_h;
  logic [2:0] eff_s;

  logic [CNT_W-1:0] wp_q, rem_q;
  logic [7:0]       run_q;
  logic             expect_q, clip_q, is_read_q;

  logic [QX_W-1:0]   qx_q;
  logic [QY_W-1:0]   qy_q;
  logic              oor_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [7:0]        rd_data_q;
  logic [7:0]        mem [STORE_DEPTH];

  logic [9:0]  lim_x, lim_y;
  logic [7:0]  qx_full, qy_full;
  logic        run_clip;
  logic [13:0] addr_full;
  logic        mem_we;
  logic [7:0]  mem_wdata;

  assign eff_w = clamp_dim(width_q, WIDTH_RST);
  assign eff_h = clamp_dim(height_q, HEIGHT_RST);
  assign eff_s = clamp_scale(scale_q);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      scale_q  <= SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_SCALE:  scale_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign run_clip = {{(CNT_W-8){1'b0}}, code_byte_i} > rem_q;

  // load state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rem_q    <= '0;
      expect_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        wp_q     <= '0;
        rem_q    <= CNT_W'(eff_w * eff_h);
        expect_q <= 1'b0;
      end
      if (cmd_i.code_pixel || cmd_i.run_step) begin
        wp_q  <= wp_q + CNT_W'(1);
        rem_q <= rem_q - CNT_W'(1);
      end
      if (cmd_i.set_expect) expect_q <= 1'b1;
      if (cmd_i.run_load)   expect_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_load) begin
      run_q  <= run_clip ? rem_q[7:0] : code_byte_i;
      clip_q <= run_clip;
    end else if (cmd_i.run_step) begin
      run_q <= run_q - 8'd1;
    end
    if (cmd_i.code_pixel) clip_q <= 1'b0;
    if (cmd_i.code_pixel || cmd_i.run_load) is_read_q <= 1'b0;
    if (cmd_i.rd_capture) is_read_q <= 1'b1;
  end

  // read address path
  assign lim_x   = 10'(eff_w * eff_s);
  assign lim_y   = 10'(eff_h * eff_s);
  assign qx_full = div_scale(read_x_i, eff_s);
  assign qy_full = div_scale(read_y_i, eff_s);
  assign addr_full = 14'(qy_q * eff_w) + 14'(qx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_capture) begin
      qx_q  <= qx_full[QX_W-1:0];
      qy_q  <= qy_full[QY_W-1:0];
      oor_q <= ({2'b00, read_x_i} >= lim_x) || ({2'b00, read_y_i} >= lim_y);
    end
    if (cmd_i.rd_addr) rd_addr_q <= addr_full[ADDR_W-1:0];
  end

  // sprite RAM: one write port, one registered read port
  assign mem_we    = cmd_i.code_pixel || cmd_i.run_step;
  assign mem_wdata = cmd_i.code_pixel ? code_byte_i : 8'd0;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wp_q[ADDR_W-1:0]] <= mem_wdata;
    rd_data_q <= mem[rd_addr_q];
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (is_read_q) begin
        pixel_value_o  <= oor_q ? 8'd0 : rd_data_q;
        image_done_o   <= 1'b0;
        overrun_o      <= 1'b0;
        out_of_range_o <= oor_q;
      end else begin
        pixel_value_o  <= 8'd0;
        image_done_o   <= 1'b1;
        overrun_o      <= clip_q;
        out_of_range_o <= 1'b0;
      end
    end
  end

  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.rem_one    = (rem_q == CNT_W'(1));
  assign sts_o.expect_run = expect_q;
  assign sts_o.code_zero  = (code_byte_i == 8'd0);
  assign sts_o.run_last   = (run_q == 8'd1);

endmodule

@@ rtl/csds_ctrl.sv @@
// ----------------------------------------------------------------------------
// csds_ctrl
// Sequencer: item acceptance, zero-run stepping, read pipeline, result handoff.
// ----------------------------------------------------------------------------
`include "cursor_sprite_decode_scale_top_defines.svh"

module csds_ctrl
  import csds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output csds_cmd_t  cmd_o,
  input  csds_sts_t  sts_i
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RUN     = 3'd1;
  localparam logic [2:0] S_RD_ADDR = 3'd2;
  localparam logic [2:0] S_RD_MEM  = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            ACT_START: cmd_o.start = 1'b1;
            ACT_CODE: begin
              if (!sts_i.rem_zero) begin
                if (sts_i.expect_run) begin
                  cmd_o.run_load = 1'b1;
                  if (!sts_i.code_zero) state_d = S_RUN;
                end else if (!sts_i.code_zero) begin
                  cmd_o.code_pixel = 1'b1;
                  if (sts_i.rem_one) state_d = S_EMIT;
                end else begin
                  cmd_o.set_expect = 1'b1;
                end
              end
            end
            ACT_READ: begin
              cmd_o.rd_capture = 1'b1;
              state_d          = S_RD_ADDR;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd_o.run_step = 1'b1;
        if (sts_i.run_last) state_d = sts_i.rem_one ? S_EMIT : S_IDLE;
      end
      S_RD_ADDR: begin
        cmd_o.rd_addr = 1'b1;
        state_d       = S_RD_MEM;
      end
      S_RD_MEM: state_d = S_EMIT;
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `CSDS_ASSERT_IMP(a_run_has_room, state_q == S_RUN, !sts_i.rem_zero,
                   "zero run stepping with no pixels left")
  `CSDS_ASSERT_IMP(a_pixel_has_room, cmd_o.code_pixel || cmd_o.run_step, !sts_i.rem_zero,
                   "sprite write past end of image")
  `CSDS_ASSERT_NXT(a_emit_lands, cmd_o.load_out, out_valid_q && state_q == S_IDLE,
                   "result load did not raise out valid")
  `CSDS_ASSERT_IMP(a_no_overwrite, cmd_o.load_out, !out_valid_q || out_ready_i,
                   "result register overwritten before taken")

endmodule

@@ rtl/cursor_sprite_decode_scale_top.sv @@
// ----------------------------------------------------------------------------
// cursor_sprite_decode_scale_top
// Cursor sprite store with zero-run decode on load and scaled pixel readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries action, code byte and read
//   coordinates; one beat per item. Action start opens a load of width*height
//   pixels, code-byte beats fill it, read beats fetch pixel (y/scale, x/scale).
//   Output channel (out_valid_o/out_ready_i) returns one beat per read and one
//   beat for the code byte that completes an image; other items give none.
//   Config channel (cfg_valid_i/cfg_ready_o) writes width, height, scale by
//   index; always ready, use only while the block is idle.
// Steps:
//   start, zero marker, ignored byte: taken in idle. Pixel byte: RAM write,
//   then result load if it ends the image. Run count (clipped to pixels left):
//   run load, then zero writes, one RAM write per cycle (single write port),
//   then result load if it ends the image. Read: capture/divide, address
//   multiply, RAM read, result load; result shows the cycle after the last.
// Reset clears the sequencer, load pointers and result valid; RAM contents are
// left as is. A stalled receiver holds the result register; the block keeps
// taking items until it has a second result to hand off.
// ----------------------------------------------------------------------------
module cursor_sprite_decode_scale_top
  import csds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i,
  // item channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] code_byte_i,
  input  logic [7:0] read_x_i,
  input  logic [7:0] read_y_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] pixel_value_o,
  output logic       image_done_o,
  output logic       overrun_o,
  output logic       out_of_range_o
);

  csds_cmd_t cmd;
  csds_sts_t sts;

  // Registers accept at any time; sequencing is the writer's job.
  assign cfg_ready_o = 1'b1;

  csds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csds_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .code_byte_i    (code_byte_i),
    .read_x_i       (read_x_i),
    .read_y_i       (read_y_i),
    .pixel_value_o  (pixel_value_o),
    .image_done_o   (image_done_o),
    .overrun_o      (overrun_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cursor sprite decode/scale block. Zero-run coded
// loads and scaled reads are sent with random bursts and gaps, and every result
// beat is compared with an in-bench model of the sprite store while the output
// side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
  import csds_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RST_CYCLES    = 12;
  // Longest silent item is a run count of 255.
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 550;
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Action 3 has no meaning; the block must drop it.
  localparam logic [1:0] ACT_NONE   = 2'd3;
  // Index 3 addresses no register.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] pixel;
    logic       image_done;
    logic       overrun;
    logic       out_of_range;
  } sprite_beat_t;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_SPARSE} rx_mode_e;

  // --------------------------------------------------------------------------
  // DUT hookup; everything starts at a known value.
  // --------------------------------------------------------------------------
  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index   = REG_WIDTH;
  logic [6:0] cfg_data    = '0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [1:0] action      = ACT_START;
  logic [7:0] code_byte   = '0;
  logic [7:0] read_x      = '0;
  logic [7:0] read_y      = '0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] pixel_value;
  logic       image_done;
  logic       overrun;
  logic       out_of_range;

  cursor_sprite_decode_scale_top uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .code_byte_i    (code_byte),
    .read_x_i       (read_x),
    .read_y_i       (read_y),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_value_o  (pixel_value),
    .image_done_o   (image_done),
    .overrun_o      (overrun),
    .out_of_range_o (out_of_range)
  );

  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Sprite model: registers as written, the pixel store, and the load cursor.
  // --------------------------------------------------------------------------
  logic [6:0] reg_width  = WIDTH_RST;
  logic [6:0] reg_height = HEIGHT_RST;
  logic [2:0] reg_scale  = SCALE_RST;

  logic [7:0] sprite_mem    [STORE_DEPTH];
  bit         pixel_written [STORE_DEPTH];  // reads only hit written entries
  int         load_ptr    = 0;
  int         load_left   = 0;
  bit         run_pending = 1'b0;            // last byte was a zero marker

  sprite_beat_t due_results[$];              // beats still owed by the block

  // Bookkeeping
  int  errors        = 0;
  int  cycles        = 0;
  int  items_applied = 0;                    // items the block acts on
  int  loads_started = 0;
  int  reads_sent    = 0;
  int  images_done   = 0;
  int  clipped_runs  = 0;
  int  cfg_writes    = 0;
  int  beats_checked = 0;
  int  burst_left    = 0;
  bit  hold_req      = 1'b0;                 // raised by a test, dropped by receiver

  // Out-of-range register values act as the nearest legal one.
  function automatic int clip_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int cur_width();
    return clip_to(int'(reg_width), MAX_WIDTH);
  endfunction

  function automatic int cur_height();
    return clip_to(int'(reg_height), MAX_HEIGHT);
  endfunction

  function automatic int cur_scale();
    return clip_to(int'(reg_scale), MAX_SCALE);
  endfunction

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic void store_px(logic [7:0] v);
    if (load_left == 0) return;
    sprite_mem[ADDR_W'(load_ptr)]    = v;
    pixel_written[ADDR_W'(load_ptr)] = 1'b1;
    load_ptr++;
    load_left--;
  endfunction

  // Out of range, or landing on a pixel that has been stored at some point.
  function automatic bit read_is_defined(logic [7:0] x, logic [7:0] y);
    int w, h, s;
    w = cur_width();
    h = cur_height();
    s = cur_scale();
    if (int'(x) >= w * s || int'(y) >= h * s) return 1'b1;
    return pixel_written[ADDR_W'((int'(y) / s) * w + int'(x) / s)];
  endfunction

  // Advance the model by one item and queue the beat it owes, if any.
  function automatic void decode_item(logic [1:0] act, logic [7:0] code,
                                      logic [7:0] x, logic [7:0] y);
    sprite_beat_t beat;
    int           w, h, s, n;
    bit           clipped;
    w       = cur_width();
    h       = cur_height();
    s       = cur_scale();
    beat    = '0;
    clipped = 1'b0;
    case (act)
      ACT_START: begin
        load_ptr    = 0;
        load_left   = w * h;
        run_pending = 1'b0;
        loads_started++;
        items_applied++;
      end
      ACT_CODE: begin
        if (load_left != 0) begin
          items_applied++;
          if (run_pending) begin
            run_pending = 1'b0;
            n = int'(code);
            if (n > load_left) begin
              n       = load_left;
              clipped = 1'b1;
            end
            repeat (n) store_px(8'd0);
          end else if (code != 8'd0) begin
            store_px(code);
          end else begin
            run_pending = 1'b1;
          end
          if (load_left == 0) begin
            run_pending     = 1'b0;
            beat.image_done = 1'b1;
            beat.overrun    = clipped;
            due_results.push_back(beat);
            images_done++;
            if (clipped) clipped_runs++;
          end
        end
      end
      ACT_READ: begin
        items_applied++;
        reads_sent++;
        if (int'(x) >= w * s || int'(y) >= h * s) begin
          beat.out_of_range = 1'b1;
        end else begin
          beat.pixel = sprite_mem[ADDR_W'((int'(y) / s) * w + int'(x) / s)];
        end
        due_results.push_back(beat);
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one beat per call, in bursts with random gaps.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [1:0] act, logic [7:0] code,
                           logic [7:0] x, logic [7:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    decode_item(act, code, x, y);
    in_valid  <= 1'b1;
    action    <= act;
    code_byte <= code;
    read_x    <= x;
    read_y    <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for the owed beats, then let any silent run finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Holds cfg_valid; the caller drops it after its last write.
  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:  reg_width  = data;
      REG_HEIGHT: reg_height = data;
      REG_SCALE:  reg_scale  = data[2:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Upper bits of the scale write are don't-care; fill them at random.
  task automatic configure(logic [6:0] w, logic [6:0] h, logic [2:0] s, bit poke_unused);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_SCALE, {4'($urandom), s});
    if (poke_unused) write_reg(REG_UNUSED, 7'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-range coordinates; skipped if no defined pixel turns up.
  task automatic random_read();
    int         w, h, s, tries;
    logic [7:0] x, y;
    bit         found;
    w     = cur_width();
    h     = cur_height();
    s     = cur_scale();
    found = 1'b0;
    for (tries = 0; tries < 8 && !found; tries++) begin
      if ($urandom_range(0, 99) < 85) begin
        x = 8'($urandom_range(0, w * s - 1));
        y = 8'($urandom_range(0, h * s - 1));
      end else begin
        x = rnd8();
        y = rnd8();
      end
      found = read_is_defined(x, y);
    end
    if (found) send_item(ACT_READ, rnd8(), x, y);
  endtask

  // One well-formed load with random content, some noise mixed in, then reads.
  task automatic random_load();
    int pick, run_pct, count;
    send_item(ACT_START, rnd8(), rnd8(), rnd8());
    while (load_left != 0) begin
      pick    = $urandom_range(0, 99);
      run_pct = (load_left > 64) ? 80 : 20;   // big images fill mostly by runs
      if (pick < 6) begin
        random_read();
      end else if (pick < 8) begin
        send_item(ACT_NONE, rnd8(), rnd8(), rnd8());
      end else if (pick == 8 && $urandom_range(0, 7) == 0) begin
        // abandon the load part way and open a fresh one
        send_item(ACT_START, rnd8(), rnd8(), rnd8());
      end else if ($urandom_range(0, 99) < run_pct) begin
        send_item(ACT_CODE, 8'd0, rnd8(), rnd8());
        if ($urandom_range(0, 9) == 0) random_read();
        pick = $urandom_range(0, 19);
        if (pick == 0) count = 0;
        else if (pick < 3 && load_left < 255) count = $urandom_range(load_left + 1, 255);
        else count = $urandom_range(1, (load_left < 255) ? load_left : 255);
        send_item(ACT_CODE, 8'(count), rnd8(), rnd8());
      end else begin
        send_item(ACT_CODE, 8'($urandom_range(1, 255)), rnd8(), rnd8());
      end
    end
    repeat ($urandom_range(4, 24)) begin
      // stray code bytes after the image is full are dropped
      if ($urandom_range(0, 9) == 0) send_item(ACT_CODE, rnd8(), rnd8(), rnd8());
      else random_read();
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset size is 64x64 at scale 1; idle code bytes and action 3 are dropped.
  task automatic test_reset_defaults();
    send_item(ACT_READ, 8'h00, 8'd64, 8'd0);
    send_item(ACT_READ, 8'hff, 8'd0, 8'd64);
    send_item(ACT_READ, 8'h5a, 8'd255, 8'd255);
    send_item(ACT_CODE, 8'h3c, 8'h00, 8'hff);
    send_item(ACT_NONE, 8'hff, 8'hff, 8'hff);
  endtask

  // 2x2 image: extreme pixel values, a zero-length run, a run past the end.
  task automatic test_zero_run_decode();
    configure(7'd2, 7'd2, 3'd1, 1'b0);
    send_item(ACT_START, 8'h00, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd255, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd1, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd0, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd0, 8'h00, 8'h00);   // run of nothing
    send_item(ACT_CODE, 8'd0, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd5, 8'h00, 8'h00);   // clipped to 2, image done
    send_item(ACT_CODE, 8'd9, 8'h00, 8'h00);   // load over, dropped
    send_item(ACT_READ, 8'h00, 8'd0, 8'd0);
    send_item(ACT_READ, 8'h00, 8'd1, 8'd0);
    send_item(ACT_READ, 8'h00, 8'd0, 8'd1);
    send_item(ACT_READ, 8'h00, 8'd1, 8'd1);
    send_item(ACT_READ, 8'h00, 8'd2, 8'd0);
  endtask

  // 3x1 at scale 4: exact run, image ended by a pixel byte, scaled edges.
  task automatic test_scaled_read();
    configure(7'd3, 7'd1, 3'd4, 1'b0);
    send_item(ACT_START, 8'h00, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd0, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'd2, 8'h00, 8'h00);
    send_item(ACT_CODE, 8'h80, 8'h00, 8'h00);
    send_item(ACT_READ, 8'h00, 8'd11, 8'd3);
    send_item(ACT_READ, 8'h00, 8'd12, 8'd0);
    send_item(ACT_READ, 8'h00, 8'd0, 8'd4);
  endtask

  // Zero and oversize register values, plus a write to the spare index.
  task automatic test_register_clamp();
    configure(7'd0, 7'd127, 3'd0, 1'b1);
    random_load();
    configure(7'd127, 7'd0, 3'd7, 1'b1);
    random_load();
    configure(7'd64, 7'd64, 3'd4, 1'b0);
    random_load();
  endtask

  // Receiver holds off while reads keep coming, so the input side backs up.
  task automatic test_backpressure();
    configure(7'd8, 7'd8, 3'd1, 1'b0);
    random_load();
    hold_req   = 1'b1;
    burst_left = 64;
    repeat (40) random_read();
  endtask

  // Random sizes and scales, mostly small, a few at the extremes.
  task automatic test_random_phases();
    int         target;
    logic [6:0] w, h;
    target = items_applied + RANDOM_ITEMS;
    while (items_applied < target) begin
      case ($urandom_range(0, 9))
        0: begin w = 7'd1; h = 7'd1; end
        1: begin w = 7'd64; h = 7'd64; end
        2: begin w = 7'd64; h = 7'($urandom_range(1, 4)); end
        3: begin w = 7'($urandom_range(1, 4)); h = 7'd64; end
        4: begin
          w = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
          h = 7'($urandom_range(0, 6));
        end
        default: begin
          w = 7'($urandom_range(1, 8));
          h = 7'($urandom_range(1, 8));
        end
      endcase
      configure(w, h, 3'($urandom_range(0, 7)), $urandom_range(0, 9) == 0);
      repeat ($urandom_range(1, 3)) random_load();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_run_decode();
    test_scaled_read();
    test_register_clamp();
    test_backpressure();
    test_random_phases();

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run: %0d items, %0d loads, %0d reads, %0d beats checked",
             items_applied, loads_started, reads_sent, beats_checked);
    $display("Run: %0d images filled, %0d clipped runs, %0d register writes",
             images_done, clipped_runs, cfg_writes);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, picked anew at random, with one
  // long hold-off on request. hold_req is cleared here once the hold is over.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_e mode;
    int       stretch, phase;
    mode    = RX_OPEN;
    stretch = 0;
    phase   = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (stretch == 0) begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        stretch = $urandom_range(20, 200);
      end
      stretch--;
      phase++;
      case (mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
        RX_QUARTER: out_ready <= (phase % 4 == 0);
        default:    out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result check: each accepted beat against the oldest owed one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_beat
    sprite_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $error("result beat with nothing owed: pixel_value %0d", pixel_value);
      end else begin
        want = due_results.pop_front();
        beats_checked++;
        if (pixel_value !== want.pixel) begin
          errors++;
          $error("pixel_value: expected %0d, got %0d", want.pixel, pixel_value);
        end
        if (image_done !== want.image_done) begin
          errors++;
          $error("image_done: expected %0b, got %0b", want.image_done, image_done);
        end
        if (overrun !== want.overrun) begin
          errors++;
          $error("overrun: expected %0b, got %0b", want.overrun, overrun);
        end
        if (out_of_range !== want.out_of_range) begin
          errors++;
          $error("out_of_range: expected %0b, got %0b", want.out_of_range, out_of_range);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats still owed", cycles, due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
